// ===== design/yrs_pkg.sv =====
package yrs_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_PAIRS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_ROWS = 1'd1;

  localparam int WIDTH_PAIRS_W = 12;
  localparam int HEIGHT_ROWS_W = 13;
  localparam logic [WIDTH_PAIRS_W-1:0] WIDTH_PAIRS_RESET = 12'd320;
  localparam logic [HEIGHT_ROWS_W-1:0] HEIGHT_ROWS_RESET = 13'd480;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // 16.16 coefficients, rounded to nearest
  localparam int COEF_W = 18;
  localparam logic signed [COEF_W-1:0] K_RCR = 18'sd91881;
  localparam logic signed [COEF_W-1:0] K_GCB = 18'sd22553;
  localparam logic signed [COEF_W-1:0] K_GCR = 18'sd46802;
  localparam logic signed [COEF_W-1:0] K_BCB = 18'sd116130;

  localparam int PROD_W = 27;
  localparam int ACC_W  = 28;

  // Where a pixel takes its chroma from
  typedef enum logic [1:0] {
    CHR_CAPTURE,  // even row, even column: take the inputs, store them in the line
    CHR_RECALL,   // odd row, even column: read the pair stored by the even row
    CHR_HOLD      // odd column: reuse the pair of the column before
  } chroma_kind_t;

  typedef struct packed {
    logic [7:0]   luma;
    logic [7:0]   cb;
    logic [7:0]   cr;
    chroma_kind_t kind;
    logic         frame_end;
  } yrs_pix_t;

  // Floor a 16.16 sum to an integer and clamp it to 0..255
  function automatic logic [7:0] clamp_fixed(input logic signed [ACC_W-1:0] acc);
    logic [7:0] res;
    if (acc < 0) begin
      res = 8'd0;
    end else if (acc[ACC_W-1:16] > 255) begin
      res = 8'd255;
    end else begin
      res = acc[23:16];
    end
    return res;
  endfunction

endpackage

// ===== design/yrs_queue.sv =====
module yrs_queue import yrs_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  logic [W-1:0]      slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on push");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue popped while empty");
`endif

endmodule

// ===== design/yrs_front.sv =====
module yrs_front import yrs_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int LINE_DEPTH = MAX_WIDTH / 2,
  localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             luma,
  input  logic [7:0]             chroma_blue,
  input  logic [7:0]             chroma_red,
  output logic                   q_push,
  output yrs_pix_t               q_pix,
  output logic [SLOT_W-1:0]      q_slot,
  input  logic                   q_full
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CLW = $clog2(MAX_WIDTH + 1);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RLW = $clog2(MAX_HEIGHT + 1);

  logic [WIDTH_PAIRS_W-1:0] width_pairs;
  logic [HEIGHT_ROWS_W-1:0] height_rows;
  logic [CW-1:0]            column_count;
  logic [RW-1:0]            row_count;

  logic [CLW-1:0] cols;
  logic [RLW-1:0] rows;
  logic [CLW-1:0] col_inc;
  logic [RLW-1:0] row_inc;
  logic [CW-1:0]  col_half;
  logic           last_col;
  logic           last_row;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign q_push    = in_valid && in_ready;

  // Saturate the frame size to what the line buffer and counters hold
  always_comb begin
    if (width_pairs == '0) begin
      cols = CLW'(2);
    end else if (width_pairs > LINE_DEPTH) begin
      cols = CLW'(2 * LINE_DEPTH);
    end else begin
      cols = CLW'({width_pairs, 1'b0});
    end
    if (height_rows == '0) begin
      rows = RLW'(1);
    end else if (height_rows > MAX_HEIGHT) begin
      rows = RLW'(MAX_HEIGHT);
    end else begin
      rows = RLW'(height_rows);
    end
  end

  assign col_inc  = CLW'(column_count) + CLW'(1);
  assign row_inc  = RLW'(row_count) + RLW'(1);
  assign last_col = (col_inc >= cols);
  assign last_row = (row_inc >= rows);
  assign col_half = column_count >> 1;

  // Classify the transaction for the back end
  always_comb begin
    q_pix.luma      = luma;
    q_pix.cb        = chroma_blue;
    q_pix.cr        = chroma_red;
    q_pix.frame_end = last_col && last_row;
    if (column_count[0]) begin
      q_pix.kind = CHR_HOLD;
    end else if (row_count[0]) begin
      q_pix.kind = CHR_RECALL;
    end else begin
      q_pix.kind = CHR_CAPTURE;
    end
    q_slot = col_half[SLOT_W-1:0];
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width_pairs <= WIDTH_PAIRS_RESET;
      height_rows <= HEIGHT_ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH_PAIRS: width_pairs <= cfg_data[WIDTH_PAIRS_W-1:0];
        REG_HEIGHT_ROWS: height_rows <= cfg_data[HEIGHT_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (q_push) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : RW'(row_inc);
      end else begin
        column_count <= CW'(col_inc);
      end
    end
  end

`ifndef SYNTHESIS
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_pix.frame_end) |=> (column_count == '0 && row_count == '0))
    else $error("raster position did not wrap at end of frame");
`endif

endmodule

// ===== design/yrs_back.sv =====
module yrs_back import yrs_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  localparam int LINE_DEPTH = MAX_WIDTH / 2,
  localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  yrs_pix_t          q_pix,
  input  logic [SLOT_W-1:0] q_slot,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic              frame_end
);

  logic [15:0] line_mem [LINE_DEPTH];
  logic [15:0] line_rd;

  logic        advance;
  logic        s1_valid;
  yrs_pix_t    s1_pix;
  logic [15:0] held_chroma;
  logic [15:0] sel_chroma;

  logic signed [8:0] cb_off;
  logic signed [8:0] cr_off;

  logic                     s2_valid;
  logic [7:0]               s2_luma;
  logic                     s2_frame_end;
  logic signed [PROD_W-1:0] s2_pr;
  logic signed [PROD_W-1:0] s2_pgb;
  logic signed [PROD_W-1:0] s2_pgr;
  logic signed [PROD_W-1:0] s2_pb;

  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_g;
  logic signed [ACC_W-1:0] acc_b;

  // Move the whole pipe whenever the output register can take a result
  assign advance = !out_valid || out_ready;
  assign q_pop   = advance && q_valid;

  // Line buffer: store captured pairs, read the slot for every popped pixel
  always_ff @(posedge clk) begin
    if (q_pop && q_pix.kind == CHR_CAPTURE) begin
      line_mem[q_slot] <= {q_pix.cr, q_pix.cb};
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      line_rd <= line_mem[q_slot];
    end
  end

  // Stage 1: hold the popped transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_pix <= q_pix;
    end
  end

  // Pick the chroma pair for this pixel
  always_comb begin
    case (s1_pix.kind)
      CHR_CAPTURE: sel_chroma = {s1_pix.cr, s1_pix.cb};
      CHR_RECALL:  sel_chroma = line_rd;
      CHR_HOLD:    sel_chroma = held_chroma;
      default:     sel_chroma = held_chroma;
    endcase
  end

  assign cb_off = $signed({1'b0, sel_chroma[7:0]}) - 9'sd128;
  assign cr_off = $signed({1'b0, sel_chroma[15:8]}) - 9'sd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_chroma <= '0;
    end else if (advance && s1_valid && s1_pix.kind != CHR_HOLD) begin
      held_chroma <= sel_chroma;
    end
  end

  // Stage 2: coefficient products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      s2_luma      <= s1_pix.luma;
      s2_frame_end <= s1_pix.frame_end;
      s2_pr        <= cr_off * K_RCR;
      s2_pgb       <= cb_off * K_GCB;
      s2_pgr       <= cr_off * K_GCR;
      s2_pb        <= cb_off * K_BCB;
    end
  end

  // Stage 3: sum, floor and clamp into the output register
  assign base  = $signed({4'b0, s2_luma, 16'h0000});
  assign acc_r = base + ACC_W'(s2_pr);
  assign acc_g = base - ACC_W'(s2_pgb) - ACC_W'(s2_pgr);
  assign acc_b = base + ACC_W'(s2_pb);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      red       <= clamp_fixed(acc_r);
      green     <= clamp_fixed(acc_g);
      blue      <= clamp_fixed(acc_b);
      frame_end <= s2_frame_end;
    end
  end

`ifndef SYNTHESIS
  a_held_stable: assert property (@(posedge clk) disable iff (rst)
    !(advance && s1_valid && s1_pix.kind != CHR_HOLD) |=> $stable(held_chroma))
    else $error("held chroma changed without a capturing or recalling pixel");
`endif

endmodule

// ===== design/yuv420_to_rgb_stream_unit.sv =====
// YCbCr 4:2:0 to RGB stream converter, full-range BT.601.
// Input channel (in_valid/in_ready): one luma sample per transaction in raster
// order; chroma_blue/chroma_red are sampled only at even rows and even columns.
// Output channel (out_valid/out_ready): one red/green/blue pixel per input, with
// frame_end high on the last pixel of the frame.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
// width_pairs (width / 2), index 1 is height_rows; write only while idle.
// cfg_ready is always high.
// Throughput: one pixel per clock while out_ready is high; every stage and
// the line buffer (one write, one read per cycle) handle one pixel per cycle.
// Path from input transaction to out_valid when the queue is empty:
// queue, line-buffer read, product stage, clamp stage into the output register.
// Reset (rst, synchronous): raster position and held chroma clear, registers
// return to 320 pairs by 480 rows; no clearing pass, the line buffer is first
// filled by the even rows.
// Stall: when out_ready is low the back pipe holds, the 4-entry queue fills, and
// in_ready drops once the queue is full.
module yuv420_to_rgb_stream_unit import yrs_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             luma,
  input  logic [7:0]             chroma_blue,
  input  logic [7:0]             chroma_red,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue,
  output logic                   frame_end
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int QW         = SLOT_W + $bits(yrs_pix_t);

  logic              f_push;
  yrs_pix_t          f_pix;
  logic [SLOT_W-1:0] f_slot;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [QW-1:0]     q_data;
  yrs_pix_t          b_pix;
  logic [SLOT_W-1:0] b_slot;

  yrs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .luma        (luma),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red),
    .q_push      (f_push),
    .q_pix       (f_pix),
    .q_slot      (f_slot),
    .q_full      (q_full)
  );

  yrs_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_slot, f_pix}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  assign b_pix  = q_data[$bits(yrs_pix_t)-1:0];
  assign b_slot = q_data[QW-1:$bits(yrs_pix_t)];

  yrs_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pix     (b_pix),
    .q_slot    (b_slot),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .frame_end (frame_end)
  );

endmodule

// ===== tb/sv/tb_yuv420_to_rgb_stream_unit.sv =====
`timescale 1ns / 1ps

module tb_yuv420_to_rgb_stream_unit;
  import yrs_pkg::*;

  localparam int LINE_SLOTS = 2048;  // chroma columns at the widest frame
  localparam int MAX_ROWS = 4096;

  // 16.16 conversion coefficients
  localparam int RED_FROM_CR = 91881;
  localparam int GREEN_FROM_CB = 22553;
  localparam int GREEN_FROM_CR = 46802;
  localparam int BLUE_FROM_CB = 116130;

  localparam int PREDICT = -1;    // directed row checked against the predictor
  localparam int NO_WRITE = -1;   // phase leaves the register alone
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int DIRECTED_ROWS = 17;
  localparam int RESET_CONFIG_ROWS = 4;
  localparam int PHASES = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } rgb_pixel_t;

  typedef struct {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
    bit         typed;
    rgb_pixel_t want;
  } pixel_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] luma = 8'd0;
  logic [7:0] chroma_blue = 8'd0;
  logic [7:0] chroma_red = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic frame_end;

  yuv420_to_rgb_stream_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .luma        (luma),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .frame_end   (frame_end)
  );

  always #5 clk = ~clk;

  // Directed pixels: luma, cb, cr, then red, green, blue, frame_end where obvious.
  // The first rows run at the reset size; the rest run at 4x2 pixels.
  int directed_rows [DIRECTED_ROWS][7] = '{
    '{  0, 128, 128,       0,   0,   0, 0},
    '{255,   0,   0,     255, 255, 255, 0},
    '{  0,   0,   0, PREDICT,   0,   0, 0},
    '{255, 255, 255, PREDICT,   0,   0, 0},
    '{255, 255,   0, PREDICT,   0,   0, 0},
    '{255,   0,   0,     255, 255, 255, 0},
    '{  0, 255, 255,       0,   0,   0, 0},
    '{128, 128, 128, PREDICT,   0,   0, 0},
    '{255, 128, 128, PREDICT,   0,   0, 0},
    '{255, 255, 255, PREDICT,   0,   0, 0},
    '{  0,   0,   0, PREDICT,   0,   0, 0},
    '{200, 128, 128,     200, 200, 200, 0},
    '{  1,   0, 255,       1,   1,   1, 0},
    '{  0,   0,   0, PREDICT,   0,   0, 0},
    '{255, 255, 255, PREDICT,   0,   0, 0},
    '{ 77,   0,   0,      77,  77,  77, 0},
    '{254, 255, 255,     254, 254, 254, 1}
  };

  // Random phases: width_pairs data, height_rows data, pixel count, output hold-off
  int phase_plan [PHASES][4] = '{
    '{1, 1, 40, 0},
    '{0, 0, 20, 0},
    '{3, 5, 60, 1},
    '{2048, 3, 50, 0},
    '{5, NO_WRITE, 40, 0},
    '{4, 4096, 60, 0},
    '{NO_WRITE, 2, 40, 0},
    '{'h1FFF, 'h1FFF, 30, 0},
    '{'h1002, 3, 60, 1},
    '{1, 7, 60, 0}
  };

  // Converter state mirrored by the predictor
  logic [WIDTH_PAIRS_W-1:0] model_pairs = WIDTH_PAIRS_RESET;
  logic [HEIGHT_ROWS_W-1:0] model_rows = HEIGHT_ROWS_RESET;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  bit [7:0] held_cb = 8'd0;
  bit [7:0] held_cr = 8'd0;
  bit [7:0] line_cb [LINE_SLOTS];
  bit [7:0] line_cr [LINE_SLOTS];
  bit line_written [LINE_SLOTS];

  pixel_item_t pixel_backlog [$];
  rgb_pixel_t pending_rgb [$];
  pixel_item_t offered;

  int cycle_count = 0;
  int mismatch_count = 0;
  int pixels_checked = 0;
  int frames_seen = 0;
  int registers_written = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int burst_left = 0;
  int gap_left = 0;
  int pattern_age = 0;
  logic [7:0] ready_pattern = 8'hFF;

  function automatic int unsigned effective_pairs(input logic [WIDTH_PAIRS_W-1:0] p);
    if (p == 0) return 1;
    if (p > LINE_SLOTS) return LINE_SLOTS;
    return 32'(p);
  endfunction

  function automatic int unsigned effective_rows(input logic [HEIGHT_ROWS_W-1:0] h);
    if (h == 0) return 1;
    if (h > MAX_ROWS) return MAX_ROWS;
    return 32'(h);
  endfunction

  // Floor a 16.16 sum and clamp it to 0..255
  function automatic logic [7:0] floor_clamp(input int acc);
    if (acc < 0) return 8'd0;
    if ((acc >>> 16) > 255) return 8'd255;
    return acc[23:16];
  endfunction

  // Convert one pixel and advance the raster position
  function automatic rgb_pixel_t predict_rgb(input logic [7:0] y, input logic [7:0] cb_in,
                                             input logic [7:0] cr_in);
    int unsigned cols;
    int unsigned rows;
    int unsigned slot;
    int cb_off;
    int cr_off;
    int base;
    bit row_done;
    bit frame_done;
    rgb_pixel_t px;
    cols = 2 * effective_pairs(model_pairs);
    rows = effective_rows(model_rows);
    slot = (col_pos / 2) % LINE_SLOTS;
    // at even columns, capture chroma on even rows, recall it from the line on odd rows
    if (col_pos % 2 == 0) begin
      if (row_pos % 2 == 0) begin
        held_cb = cb_in;
        held_cr = cr_in;
        line_cb[slot] = cb_in;
        line_cr[slot] = cr_in;
        line_written[slot] = 1'b1;
      end else begin
        held_cb = line_cb[slot];
        held_cr = line_cr[slot];
      end
    end
    cb_off = int'(held_cb) - 128;
    cr_off = int'(held_cr) - 128;
    base = int'(y) * 65536;
    px.red = floor_clamp(base + RED_FROM_CR * cr_off);
    px.green = floor_clamp(base - GREEN_FROM_CB * cb_off - GREEN_FROM_CR * cr_off);
    px.blue = floor_clamp(base + BLUE_FROM_CB * cb_off);
    row_done = (col_pos + 1 >= cols);
    frame_done = (row_pos + 1 >= rows);
    px.frame_end = row_done && frame_done;
    if (row_done) begin
      col_pos = 0;
      row_pos = frame_done ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return px;
  endfunction

  // A new width may not make an odd row read line entries never filled
  function automatic bit width_write_safe(input logic [CFG_DATA_W-1:0] data);
    int unsigned pairs;
    pairs = effective_pairs(data[WIDTH_PAIRS_W-1:0]);
    if (row_pos % 2 == 0) return 1'b1;
    for (int i = 0; i < pairs; i++) begin
      if (!line_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[cycle %0d] mismatch: %s", cycle_count, what);
  endtask

  task automatic queue_random_pixels(input int count);
    pixel_item_t item;
    for (int i = 0; i < count; i++) begin
      item.luma = pick_sample();
      item.cb = pick_sample();
      item.cr = pick_sample();
      item.typed = 1'b0;
      item.want = '0;
      pixel_backlog.push_back(item);
    end
  endtask

  // Wait until every queued pixel is accepted and every result has come back
  task automatic wait_drained();
    while (pixel_backlog.size() != 0 || in_valid || pending_rgb.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    // transaction taken at this edge: mirror it and release the channel
    if (index == REG_WIDTH_PAIRS) model_pairs = data[WIDTH_PAIRS_W-1:0];
    else if (index == REG_HEIGHT_ROWS) model_rows = data[HEIGHT_ROWS_W-1:0];
    registers_written++;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_pixel();
    rgb_pixel_t want;
    pixels_checked++;
    if (frame_end === 1'b1) frames_seen++;
    if (pending_rgb.size() == 0) begin
      report_mismatch("pixel output with no pixel pending");
      return;
    end
    want = pending_rgb.pop_front();
    if (red !== want.red || green !== want.green || blue !== want.blue ||
        frame_end !== want.frame_end) begin
      report_mismatch($sformatf("pixel %0d: got %0d/%0d/%0d end %b, want %0d/%0d/%0d end %b",
                                pixels_checked, red, green, blue, frame_end,
                                want.red, want.green, want.blue, want.frame_end));
    end
  endtask

  // Sender: offer pixels in bursts, hold each until its transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (offered.typed) begin
          void'(predict_rgb(offered.luma, offered.cb, offered.cr));
          pending_rgb.push_back(offered.want);
        end else begin
          pending_rgb.push_back(predict_rgb(offered.luma, offered.cb, offered.cr));
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          offered = pixel_backlog.pop_front();
          luma <= offered.luma;
          chroma_blue <= offered.cb;
          chroma_red <= offered.cr;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transaction, stall on a rotating pattern or a long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_pixel();
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (pattern_age == 0) begin
        pattern_age = 32;
        case ($urandom_range(0, 3))
          0: ready_pattern = 8'hFF;
          1: ready_pattern = 8'($urandom);
          2: ready_pattern = 8'b1110_1110;
          default: ready_pattern = 8'b1000_0000;
        endcase
      end
      pattern_age--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("no completion within %0d cycles", CYCLE_LIMIT);
      $display("yuv420_to_rgb_stream_unit regression: fail");
      $finish;
    end
  end

  initial begin
    pixel_item_t item;
    int unsigned cols_now;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows: start at the reset size, then shrink to 4x2 mid-row
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (r == RESET_CONFIG_ROWS) begin
        wait_drained();
        write_register(REG_WIDTH_PAIRS, CFG_DATA_W'(2));
        write_register(REG_HEIGHT_ROWS, CFG_DATA_W'(2));
        @(negedge clk);
      end
      item.luma = 8'(directed_rows[r][0]);
      item.cb = 8'(directed_rows[r][1]);
      item.cr = 8'(directed_rows[r][2]);
      item.typed = (directed_rows[r][3] != PREDICT);
      item.want.red = 8'(directed_rows[r][3]);
      item.want.green = 8'(directed_rows[r][4]);
      item.want.blue = 8'(directed_rows[r][5]);
      item.want.frame_end = 1'(directed_rows[r][6]);
      pixel_backlog.push_back(item);
    end
    wait_drained();

    // Random phases, resized only while the converter is idle
    for (int p = 0; p < PHASES; p++) begin
      if (phase_plan[p][0] != NO_WRITE) begin
        if (!width_write_safe(CFG_DATA_W'(phase_plan[p][0]))) begin
          // finish the odd row so the next row refills the line
          cols_now = 2 * effective_pairs(model_pairs);
          queue_random_pixels((col_pos < cols_now) ? cols_now - col_pos : 1);
          wait_drained();
        end
        write_register(REG_WIDTH_PAIRS, CFG_DATA_W'(phase_plan[p][0]));
      end
      if (phase_plan[p][1] != NO_WRITE) begin
        write_register(REG_HEIGHT_ROWS, CFG_DATA_W'(phase_plan[p][1]));
      end
      @(negedge clk);
      if (phase_plan[p][3] != 0) hold_requests++;
      queue_random_pixels(phase_plan[p][2]);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d pixels checked across %0d register writes, %0d frame ends seen",
             pixels_checked, registers_written, frames_seen);
    $display("sizes from 1 pair by 1 row up to 2048 pairs by 4096 rows, mid-frame shrinks,");
    $display("out-of-range register values and a %0d-cycle output hold-off", HOLD_OFF_CYCLES);
    if (mismatch_count == 0) begin
      $display("yuv420_to_rgb_stream_unit regression: pass");
    end else begin
      $display("yuv420_to_rgb_stream_unit regression: fail");
    end
    $finish;
  end

endmodule
